[sv/cpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closed polygon perimeter package
// Widths, derived sizes and the sequencer state type shared by the block.
// ----------------------------------------------------------------------------
package cpp_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int SUM_BITS   = 41;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int SUMSQ_W = SQ_W + 1;
	localparam int ROOT_W  = COORD_BITS + FRAC_BITS + 1;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 1;
	localparam int CNT_W   = $clog2(ROOT_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_ACC,
		ST_EMIT
	} cpp_state_t;

endpackage : cpp_pkg
`default_nettype wire

[sv/cpp_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel that carries one polygon vertex per transfer.
// ----------------------------------------------------------------------------
interface cpp_in_if import cpp_pkg::*; ();

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_coord;
	logic signed [COORD_BITS-1:0] y_coord;
	logic                         last_point;

	modport source (output valid, output x_coord, output y_coord, output last_point,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input last_point,
		output ready);

endinterface : cpp_in_if
`default_nettype wire

[sv/cpp_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Perimeter channel
// Valid/ready channel that carries one polygon perimeter per transfer.
// ----------------------------------------------------------------------------
interface cpp_out_if import cpp_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [SUM_BITS-1:0] perimeter;
	logic                saturated;

	modport source (output valid, output perimeter, output saturated, input ready);
	modport sink (input valid, input perimeter, input saturated, output ready);

endinterface : cpp_out_if
`default_nettype wire

[sv/closed_polygon_perimeter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closed polygon perimeter
// Sums the edge lengths of a polygon given vertex by vertex and emits the
// closed perimeter on the final vertex.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer; the final one carries last_point. Each
// edge length is the floor of its Euclidean length with 8 fraction bits, and
// the perimeter saturates at its maximum with the saturated flag set. The
// first vertex of a polygon is only stored, and goes straight on to the
// output register when it is also the final one. Every later vertex passes
// through the accepting state, the ST_SQX and ST_SQY states on the shared
// squarer, 25 steps of the bit-serial square root and the accumulate state.
// The final vertex then runs those steps again for the closing edge, and the
// sum is loaded into the output register. A finished perimeter waits in the
// output register while the next polygon starts; the final vertex of that
// polygon stalls until the register has been read.
// ----------------------------------------------------------------------------
module closed_polygon_perimeter import cpp_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	cpp_in_if.sink   vtx,
	cpp_out_if.source res
);

	cpp_state_t state_q, state_d;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                         last_q;
	logic                         have_first_q;
	logic                         closing_q;
	logic [SUM_BITS-1:0]          sum_q;
	logic                         clamped_q;
	logic [SQ_W-1:0]              sq_q;
	logic [RAD_W-1:0]             rad_q;
	logic [REM_W-1:0]             rem_q;
	logic [ROOT_W-1:0]            root_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         out_valid_q;
	logic [SUM_BITS-1:0]          out_perim_q;
	logic                         out_sat_q;

	logic                         in_take;
	logic                         out_free;
	logic signed [COORD_BITS-1:0] bx, by;
	logic [DIFF_W-1:0]            dx, dy, ax_abs, ay_abs;
	logic [COORD_BITS-1:0]        mul_op;
	logic [SQ_W-1:0]              prod;
	logic [SUMSQ_W-1:0]           sumsq;
	logic [REM_W+1:0]             rem_sh, trial;
	logic                         ge;
	logic [SUM_BITS:0]            tot;

	assign out_free = !out_valid_q || res.ready;
	assign in_take  = vtx.valid && vtx.ready;

	assign bx = closing_q ? first_x_q : prev_x_q;
	assign by = closing_q ? first_y_q : prev_y_q;
	assign dx = {cur_x_q[COORD_BITS-1], cur_x_q} - {bx[COORD_BITS-1], bx};
	assign dy = {cur_y_q[COORD_BITS-1], cur_y_q} - {by[COORD_BITS-1], by};
	assign ax_abs = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
	assign ay_abs = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;

	assign mul_op = (state_q == ST_SQX) ? ax_abs[COORD_BITS-1:0] : ay_abs[COORD_BITS-1:0];
	assign prod   = mul_op * mul_op;
	assign sumsq  = {1'b0, sq_q} + {1'b0, prod};

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	assign tot = {1'b0, sum_q} + (SUM_BITS + 1)'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		vtx.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				vtx.ready = 1'b1;
				if (vtx.valid) begin
					if (have_first_q) begin
						state_d = ST_SQX;
					end else if (vtx.last_point) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SQX: state_d = ST_SQY;
			ST_SQY: state_d = ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == '0) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (last_q && !closing_q) begin
					state_d = ST_SQX;
				end else if (last_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			last_q       <= 1'b0;
			have_first_q <= 1'b0;
			closing_q    <= 1'b0;
			sum_q        <= '0;
			clamped_q    <= 1'b0;
			sq_q         <= '0;
			rad_q        <= '0;
			rem_q        <= '0;
			root_q       <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_perim_q  <= '0;
			out_sat_q    <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						cur_x_q   <= vtx.x_coord;
						cur_y_q   <= vtx.y_coord;
						last_q    <= vtx.last_point;
						closing_q <= 1'b0;
						if (!have_first_q) begin
							first_x_q    <= vtx.x_coord;
							first_y_q    <= vtx.y_coord;
							prev_x_q     <= vtx.x_coord;
							prev_y_q     <= vtx.y_coord;
							have_first_q <= 1'b1;
						end
					end
				end
				ST_SQX: sq_q <= prod;
				ST_SQY: begin
					rad_q  <= RAD_W'(sumsq) << (2 * FRAC_BITS);
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CNT_W'(ROOT_W - 1);
				end
				ST_ROOT: begin
					rad_q  <= rad_q << 2;
					rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
					root_q <= {root_q[ROOT_W-2:0], ge};
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				ST_ACC: begin
					if (tot[SUM_BITS]) begin
						sum_q     <= '1;
						clamped_q <= 1'b1;
					end else begin
						sum_q <= tot[SUM_BITS-1:0];
					end
					if (!closing_q) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
					end
					closing_q <= last_q;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_perim_q  <= sum_q;
						out_sat_q    <= clamped_q;
						first_x_q    <= '0;
						first_y_q    <= '0;
						prev_x_q     <= '0;
						prev_y_q     <= '0;
						have_first_q <= 1'b0;
						sum_q        <= '0;
						clamped_q    <= 1'b0;
						closing_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.valid     = out_valid_q;
	assign res.perimeter = out_perim_q;
	assign res.saturated = out_sat_q;

endmodule : closed_polygon_perimeter
`default_nettype wire
